/* rtl/core/esw_pkg.sv */
package esw_pkg;

    // pulse counter width; the count difference wraps at this width
    localparam int COUNT_W = 32;

    // field and register widths
    localparam int TIME_W  = 32;
    localparam int CNT_IN_W = 32;
    localparam int REG_W   = 16;
    localparam int VAL_W   = 16;
    localparam int IDX_W   = 8;

    // scale constants
    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] CPS_SCALE = SCALE_W'(1000);
    localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(60);

    // divider sizing: quotient is only needed up to the saturation point
    localparam int PROD_W = CNT_IN_W + SCALE_W;
    localparam int QUOT_W = VAL_W + 1;
    localparam int REM_W  = REG_W + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W + 1);

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // register indexes
    localparam logic [IDX_W-1:0] REG_SAMPLE_MS      = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PULSES_PER_REV = IDX_W'(1);

    // reset values
    localparam logic [REG_W-1:0] SAMPLE_MS_RST      = REG_W'(100);
    localparam logic [REG_W-1:0] PULSES_PER_REV_RST = REG_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CPS,
        ST_START_CPS,
        ST_WAIT_CPS,
        ST_MUL_RPM,
        ST_START_RPM,
        ST_WAIT_RPM,
        ST_DONE
    } state_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

    typedef struct packed {
        logic             clip;
        logic [VAL_W-1:0] val;
    } sat_t;

    // apply sign to a quotient magnitude and saturate to 16 bit signed
    function automatic sat_t sat_quot(input logic neg, input logic ovf,
                                      input logic [QUOT_W-1:0] q);
        sat_t r;
        r.clip = 1'b0;
        r.val  = '0;
        if (neg) begin
            if (ovf || q > QUOT_W'(VAL_MIN)) begin
                r.clip = 1'b1;
                r.val  = VAL_MIN;
            end else begin
                r.val = VAL_W'(-q);
            end
        end else begin
            if (ovf || q > QUOT_W'(VAL_MAX)) begin
                r.clip = 1'b1;
                r.val  = VAL_MAX;
            end else begin
                r.val = VAL_W'(q);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/esw_if.sv */
interface esw_in_if;
    logic                                valid;
    logic                                ready;
    logic [esw_pkg::TIME_W-1:0]          now_ms;
    logic signed [esw_pkg::CNT_IN_W-1:0] pulse_total;

    modport source (output valid, output now_ms, output pulse_total, input ready);
    modport sink   (input valid, input now_ms, input pulse_total, output ready);
endinterface

interface esw_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [esw_pkg::VAL_W-1:0] cps;
    logic signed [esw_pkg::VAL_W-1:0] rpm;
    logic                             updated;
    logic                             clipped;

    modport source (output valid, output cps, output rpm, output updated,
                    output clipped, input ready);
    modport sink   (input valid, input cps, input rpm, input updated,
                    input clipped, output ready);
endinterface

/* rtl/core/esw_div.sv */
module esw_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [esw_pkg::PROD_W-1:0]   dividend,
    input  logic [esw_pkg::REG_W-1:0]    divisor,
    output esw_pkg::div_res_t            res
);

    logic [esw_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [esw_pkg::REM_W-1:0]  den_reg, den_next;
    logic [esw_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [esw_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       ovf_reg, ovf_next;
    logic                       fits;

    // one restoring step per cycle
    assign fits = (rem_reg >= den_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (start)
        begin
            // quotient too large for the saturation range is flagged up front
            ovf_next  = (dividend >= (esw_pkg::PROD_W'(divisor) << esw_pkg::QUOT_W));
            rem_next  = dividend[esw_pkg::REM_W-1:0];
            den_next  = esw_pkg::REM_W'(divisor) << (esw_pkg::QUOT_W - 1);
            quot_next = '0;
            step_next = esw_pkg::STEP_W'(esw_pkg::QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - den_reg;
            end
            quot_next = {quot_reg[esw_pkg::QUOT_W-2:0], fits};
            den_next  = den_reg >> 1;
            step_next = step_reg - esw_pkg::STEP_W'(1);
            if (step_reg == esw_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule

/* rtl/core/encoder_speed_window_core.sv */
// Windowed encoder speed meter. Each input word carries the current millisecond
// time and the signed pulse count. When at least sample_ms milliseconds have
// passed since the last window closed, counts per second are recomputed as
// (count delta) * 1000 / sample_ms; otherwise the held value is returned.
// rpm = cps * 60 / pulses_per_rev is produced for every word, and both values
// saturate to 16 bit signed with the clipped flag set. One word is processed
// at a time through a single shared 17-step restoring divider: a word that
// closes a window runs two divisions, and a word that reuses the held value
// runs one division. The next word can be accepted once the sequencer is back
// in idle, after the result has moved to the output register; a finished word
// waits there longer only while the previous result is still untaken.
// The result sits in an output register, so the next word may be accepted while
// it waits. A register value of 0 for either divisor acts as 1. Register writes
// are taken at any time but are meant for when the block is idle.
module encoder_speed_window_core (
    input  logic                        clk,
    input  logic                        rst_n,
    esw_in_if.sink                      in_ch,
    esw_out_if.source                   out_ch,
    input  logic                        cfg_we,
    input  logic [esw_pkg::IDX_W-1:0]   cfg_idx,
    input  logic [esw_pkg::REG_W-1:0]   cfg_data
);

    esw_pkg::state_t state_reg, state_next;

    logic [esw_pkg::REG_W-1:0]    sample_ms_reg;
    logic [esw_pkg::REG_W-1:0]    ppr_reg;
    logic [esw_pkg::CNT_IN_W-1:0] prev_count_reg;
    logic [esw_pkg::TIME_W-1:0]   prev_time_reg;
    logic [esw_pkg::VAL_W-1:0]    held_cps_reg;

    logic [esw_pkg::TIME_W-1:0]   now_reg;
    logic [esw_pkg::CNT_IN_W-1:0] count_reg;
    logic                         upd_reg;
    logic                         neg_reg;
    logic                         clip_reg;
    logic [esw_pkg::PROD_W-1:0]   prod_reg;
    logic [esw_pkg::REG_W-1:0]    den_reg;
    logic [esw_pkg::VAL_W-1:0]    rpm_reg;

    logic                         out_valid_reg;
    logic [esw_pkg::VAL_W-1:0]    out_cps_reg;
    logic [esw_pkg::VAL_W-1:0]    out_rpm_reg;
    logic                         out_upd_reg;
    logic                         out_clip_reg;

    logic                         accept;
    logic                         div_start;
    logic                         out_free;
    logic [esw_pkg::TIME_W-1:0]   elapsed;
    logic                         window_closed;
    logic [esw_pkg::CNT_IN_W-1:0] diff_raw;
    logic [esw_pkg::CNT_IN_W-1:0] diff;
    logic [esw_pkg::CNT_IN_W-1:0] diff_abs;
    logic [esw_pkg::VAL_W-1:0]    cps_abs;
    esw_pkg::div_res_t            div_res;
    esw_pkg::sat_t                sat_res;

    // shared divider
    esw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .res      (div_res)
    );

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // window check and wrapping count delta
    assign elapsed       = in_ch.now_ms - prev_time_reg;
    assign window_closed = (elapsed >= esw_pkg::TIME_W'(sample_ms_reg));
    assign diff_raw      = count_reg - prev_count_reg;
    assign diff          = esw_pkg::CNT_IN_W'(signed'(diff_raw[esw_pkg::COUNT_W-1:0]));
    assign diff_abs      = diff[esw_pkg::CNT_IN_W-1] ? -diff : diff;
    assign cps_abs       = held_cps_reg[esw_pkg::VAL_W-1] ? -held_cps_reg : held_cps_reg;
    assign sat_res       = esw_pkg::sat_quot(neg_reg, div_res.ovf, div_res.quot);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            esw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = window_closed ? esw_pkg::ST_MUL_CPS : esw_pkg::ST_MUL_RPM;
                end
            end
            esw_pkg::ST_MUL_CPS:   state_next = esw_pkg::ST_START_CPS;
            esw_pkg::ST_START_CPS: state_next = esw_pkg::ST_WAIT_CPS;
            esw_pkg::ST_WAIT_CPS:
            begin
                if (div_res.done)
                begin
                    state_next = esw_pkg::ST_MUL_RPM;
                end
            end
            esw_pkg::ST_MUL_RPM:   state_next = esw_pkg::ST_START_RPM;
            esw_pkg::ST_START_RPM: state_next = esw_pkg::ST_WAIT_RPM;
            esw_pkg::ST_WAIT_RPM:
            begin
                if (div_res.done)
                begin
                    state_next = esw_pkg::ST_DONE;
                end
            end
            esw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = esw_pkg::ST_IDLE;
                end
            end
            default: state_next = esw_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            esw_pkg::ST_IDLE:      in_ch.ready = 1'b1;
            esw_pkg::ST_START_CPS: div_start   = 1'b1;
            esw_pkg::ST_START_RPM: div_start   = 1'b1;
            default:
            begin
                in_ch.ready = 1'b0;
                div_start   = 1'b0;
            end
        endcase
    end

    // control state, registers and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= esw_pkg::ST_IDLE;
            sample_ms_reg  <= esw_pkg::SAMPLE_MS_RST;
            ppr_reg        <= esw_pkg::PULSES_PER_REV_RST;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            held_cps_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    esw_pkg::REG_SAMPLE_MS:      sample_ms_reg <= cfg_data;
                    esw_pkg::REG_PULSES_PER_REV: ppr_reg       <= cfg_data;
                    default:                     ;
                endcase
            end
            if (state_reg == esw_pkg::ST_WAIT_CPS && div_res.done)
            begin
                held_cps_reg   <= sat_res.val;
                prev_count_reg <= count_reg;
                prev_time_reg  <= now_reg;
            end
            if (state_reg == esw_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            esw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    now_reg   <= in_ch.now_ms;
                    count_reg <= in_ch.pulse_total;
                    upd_reg   <= window_closed;
                    clip_reg  <= 1'b0;
                end
            end
            esw_pkg::ST_MUL_CPS:
            begin
                prod_reg <= esw_pkg::PROD_W'(diff_abs) * esw_pkg::PROD_W'(esw_pkg::CPS_SCALE);
                neg_reg  <= diff[esw_pkg::CNT_IN_W-1];
                den_reg  <= (sample_ms_reg == '0) ? esw_pkg::REG_W'(1) : sample_ms_reg;
            end
            esw_pkg::ST_WAIT_CPS:
            begin
                if (div_res.done)
                begin
                    clip_reg <= sat_res.clip;
                end
            end
            esw_pkg::ST_MUL_RPM:
            begin
                prod_reg <= esw_pkg::PROD_W'(cps_abs) * esw_pkg::PROD_W'(esw_pkg::RPM_SCALE);
                neg_reg  <= held_cps_reg[esw_pkg::VAL_W-1];
                den_reg  <= (ppr_reg == '0) ? esw_pkg::REG_W'(1) : ppr_reg;
            end
            esw_pkg::ST_WAIT_RPM:
            begin
                if (div_res.done)
                begin
                    rpm_reg  <= sat_res.val;
                    clip_reg <= clip_reg | sat_res.clip;
                end
            end
            esw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_cps_reg  <= held_cps_reg;
                    out_rpm_reg  <= rpm_reg;
                    out_upd_reg  <= upd_reg;
                    out_clip_reg <= clip_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.cps     = out_cps_reg;
    assign out_ch.rpm     = out_rpm_reg;
    assign out_ch.updated = out_upd_reg;
    assign out_ch.clipped = out_clip_reg;

    // divider finishes only while the sequencer waits on it
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == esw_pkg::ST_WAIT_CPS ||
                          state_reg == esw_pkg::ST_WAIT_RPM))
        else $error("divider done outside a wait state");

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("ready right after accepting a word");

    // a result only appears after a finished computation
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg == esw_pkg::ST_DONE))
        else $error("result presented without finishing");

    // held value moves only when a window closes
    a_held_on_window: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(held_cps_reg) |-> $past(state_reg == esw_pkg::ST_WAIT_CPS && upd_reg))
        else $error("held cps changed outside a closing window");

endmodule
